// ===== design/mexp_pkg.sv =====
// Package for the modular exponentiation block.
// Holds widths, the modulus reset value and the controller/datapath interface structs.
// No dependencies.
`default_nettype none
package mexp_pkg;
  localparam int ModBits = 31;
  localparam int BaseBits = 63;
  localparam int ExpBits = 64;
  localparam int DivBits = 64;
  localparam int CntBits = 6;
  localparam logic [ModBits-1:0] ModReset = 31'd1000000007;

  typedef struct packed {
    logic load;
    logic step;
    logic ld_mul;
    logic ld_sq;
    logic wr_acc;
    logic wr_x;
    logic zero_acc;
    logic shift_e;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic e_zero;
    logic e_lsb;
    logic r_zero;
    logic m_small;
  } sts_t;
endpackage
`default_nettype wire

// ===== design/mexp_dp.sv =====
// Datapath of the modular exponentiation block: operand registers, two 31x31
// multipliers and a bit-serial restoring reduction unit. Depends on mexp_pkg.
`default_nettype none
module mexp_dp
  import mexp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic                in_opcode,
  input  wire logic [BaseBits-1:0] in_base,
  input  wire logic [ExpBits-1:0]  in_exponent,
  input  wire logic                cfg_we,
  input  wire logic [ModBits-1:0]  cfg_data,
  output logic      [ModBits-1:0]  result
);
  logic [ModBits-1:0] modulus;
  logic [ModBits-1:0] acc;
  logic [ModBits-1:0] x;
  logic [ExpBits-1:0] e;
  logic [DivBits-1:0] dsh;
  logic [ModBits:0]   r;
  logic [CntBits-1:0] cnt;
  logic [ModBits:0]   r_shift;
  logic [ModBits:0]   r_next;
  logic [2*ModBits-1:0] mul_a;
  logic [2*ModBits-1:0] mul_s;

  assign r_shift = {r[ModBits-1:0], dsh[DivBits-1]};
  assign r_next = (r_shift >= {1'b0, modulus}) ? r_shift - {1'b0, modulus} : r_shift;
  assign mul_a = {{ModBits{1'b0}}, acc} * {{ModBits{1'b0}}, x};
  assign mul_s = {{ModBits{1'b0}}, x} * {{ModBits{1'b0}}, x};

  assign sts.div_done = cmd.step && (cnt == {CntBits{1'b1}});
  assign sts.e_zero = (e == '0);
  assign sts.e_lsb = e[0];
  assign sts.r_zero = (r == '0);
  assign sts.m_small = (modulus < ModBits'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ModReset;
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dsh <= {1'b0, in_base};
      e <= in_opcode ? {{(ExpBits-ModBits){1'b0}}, modulus - ModBits'(2)} : in_exponent;
      r <= '0;
      cnt <= '0;
    end else if (cmd.ld_mul) begin
      dsh <= {{(DivBits-2*ModBits){1'b0}}, mul_a};
      r <= '0;
      cnt <= '0;
    end else if (cmd.ld_sq) begin
      dsh <= {{(DivBits-2*ModBits){1'b0}}, mul_s};
      r <= '0;
      cnt <= '0;
    end else if (cmd.step) begin
      dsh <= {dsh[DivBits-2:0], 1'b0};
      r <= r_next;
      cnt <= cnt + CntBits'(1);
    end
    if (cmd.zero_acc) begin
      acc <= '0;
    end else if (cmd.load) begin
      acc <= ModBits'(1);
    end else if (cmd.wr_acc) begin
      acc <= r[ModBits-1:0];
    end
    if (cmd.wr_x) begin
      x <= r[ModBits-1:0];
    end
    if (cmd.shift_e) begin
      e <= {1'b0, e[ExpBits-1:1]};
    end
    if (cmd.out_load) begin
      result <= acc;
    end
  end
endmodule
`default_nettype wire

// ===== design/mexp_ctrl.sv =====
// Controller of the modular exponentiation block: sequences base reduction and
// the square-and-multiply loop, and runs the stream handshakes. Depends on mexp_pkg.
`default_nettype none
module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RBASE = 3'd1;
  localparam logic [2:0] S_BCHK = 3'd2;
  localparam logic [2:0] S_LOOP = 3'd3;
  localparam logic [2:0] S_RMUL = 3'd4;
  localparam logic [2:0] S_AMUL = 3'd5;
  localparam logic [2:0] S_RSQ = 3'd6;
  localparam logic [2:0] S_OUT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       sq_done;
  logic       sq_done_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    sq_done_next = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.m_small) begin
            state_next = S_OUT;
          end else begin
            state_next = S_RBASE;
          end
        end
      end
      S_RBASE: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          state_next = S_BCHK;
        end
      end
      S_BCHK: begin
        cmd.wr_x = 1'b1;
        state_next = sts.r_zero ? S_OUT : S_LOOP;
      end
      S_LOOP: begin
        if (sq_done) begin
          cmd.wr_x = 1'b1;
          cmd.shift_e = 1'b1;
        end else if (sts.e_zero) begin
          state_next = S_OUT;
        end else if (sts.e_lsb) begin
          cmd.ld_mul = 1'b1;
          state_next = S_RMUL;
        end else begin
          cmd.ld_sq = 1'b1;
          state_next = S_RSQ;
        end
      end
      S_RMUL: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          state_next = S_AMUL;
        end
      end
      S_AMUL: begin
        cmd.wr_acc = 1'b1;
        cmd.ld_sq = 1'b1;
        state_next = S_RSQ;
      end
      S_RSQ: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          sq_done_next = 1'b1;
          state_next = S_LOOP;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (state == S_OUT && !cmd.out_load) begin
      cmd.zero_acc = 1'b0;
    end
    if ((state == S_IDLE && in_valid && sts.m_small) ||
        (state == S_BCHK && sts.r_zero)) begin
      cmd.zero_acc = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sq_done <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sq_done <= sq_done_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: stream ports, configuration port,
// and the controller and datapath. Depends on mexp_pkg, mexp_ctrl and mexp_dp.
// One item is worked at a time. The block accepts the beat, reduces the base and
// checks for a zero base. Each exponent bit up to the highest set one costs a modular
// squaring, and a set bit adds a modular multiplication before it, both done in the
// bit-serial reduction unit. The item then finishes through the output state. A
// modulus below two goes straight to the output state with a zero result, and a base
// that reduces to zero does so after the zero-base check. A result that is not taken
// holds the block in its output state. A finished result waits in the output register
// while the next beat is accepted.
`default_nettype none
module modular_exponentiation
  import mexp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [127:0]  s_tdata,  // base [62:0], exponent [126:63], zero pad [127]
  input  wire logic          s_tuser,  // opcode [0]
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [31:0]        m_tdata,  // result [30:0], zero pad [31]
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [ModBits-1:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  logic [ModBits-1:0] result;

  assign cfg_ready = 1'b1;
  assign m_tdata = {1'b0, result};

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mexp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_opcode   (s_tuser),
    .in_base     (s_tdata[62:0]),
    .in_exponent (s_tdata[126:63]),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .result      (result)
  );
endmodule
`default_nettype wire
